// ----- design/nearest_point_search_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-point search block
// Immediate-consequence and next-cycle checks clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_TOP_DEFINES_SVH
`define NEAREST_POINT_SEARCH_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- design/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// nps_pkg
// Types, sizes and helpers shared by the nearest-point search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

	localparam int MAX_POINTS   = 256;
	localparam int COORD_BITS   = 24;
	localparam int ADDR_BITS    = $clog2(MAX_POINTS);
	localparam int CNT_BITS     = $clog2(MAX_POINTS + 1);
	localparam int SQ_BITS      = 2 * COORD_BITS;
	localparam int DIST_BITS    = SQ_BITS + 2;
	localparam int DRAIN_CYCLES = 3;
	localparam int DRAIN_BITS   = 2;

	typedef enum logic [1:0] {
		OP_LOAD      = 2'd0,
		OP_CLEAR     = 2'd1,
		OP_QUERY_PT  = 2'd2,
		OP_QUERY_IDX = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAPTURE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

	// Candidate leaving the distance pipeline.
	typedef struct packed {
		logic                 valid;
		logic [ADDR_BITS-1:0] idx;
		point_t               pt;
		logic [DIST_BITS-1:0] sq_sum;
	} cand_t;

	// Magnitude of the difference of two signed coordinates; always fits COORD_BITS.
	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		logic [COORD_BITS:0]        m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[COORD_BITS] ? (~d + (COORD_BITS+1)'(1)) : d;
		return m[COORD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- design/nearest_point_search_top.sv -----
// ----------------------------------------------------------------------------
// nearest_point_search_top
// Brute-force nearest-neighbour search over a ring of stored 3D points.
// ----------------------------------------------------------------------------
// Points live in a ring of 256 cells. A load shifts the new point in at the
// ring's entry (a load into a full set is dropped) and, like a clear, completes
// with busy staying low and no result. A query rotates the whole
// ring once past a single distance pipeline, one point per cycle, so its cost
// is fixed by the ring length: a query by point holds busy through the
// rotation, the pipeline drain and a finish state that settles the winner,
// and a query by index first makes one more rotation to fetch the query
// point. The result item appears for one cycle with done high, in the first
// cycle in which busy is low again; a bad index is reported in the cycle
// after the command. The receiver cannot stall the block, so results must be
// taken on sight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_point_search_top_defines.svh"

module nearest_point_search_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output      logic                                  busy,
	input  wire logic [1:0]                            operation,
	input  wire logic signed [nps_pkg::COORD_BITS-1:0] px,
	input  wire logic signed [nps_pkg::COORD_BITS-1:0] py,
	input  wire logic signed [nps_pkg::COORD_BITS-1:0] pz,
	input  wire logic [nps_pkg::ADDR_BITS-1:0]         query_index,
	output      logic                                  done,
	output      logic signed [nps_pkg::COORD_BITS-1:0] nearest_x,
	output      logic signed [nps_pkg::COORD_BITS-1:0] nearest_y,
	output      logic signed [nps_pkg::COORD_BITS-1:0] nearest_z,
	output      logic [nps_pkg::ADDR_BITS-1:0]         nearest_index,
	output      logic                                  found,
	output      logic                                  bad_index
);

	nps_pkg::state_t               state_q, state_d;
	logic [nps_pkg::ADDR_BITS-1:0] step_q;
	logic [nps_pkg::CNT_BITS-1:0]  count_q;
	logic                          skip_en_q;
	logic [nps_pkg::ADDR_BITS-1:0] skip_q;
	nps_pkg::point_t               query_q;
	logic [nps_pkg::DRAIN_BITS-1:0] drain_q;
	logic                          have_q;
	logic [nps_pkg::ADDR_BITS-1:0] best_idx_q;
	nps_pkg::point_t               best_pt_q;
	logic [nps_pkg::DIST_BITS-1:0] best_dist_q;
	logic                          done_q;
	nps_pkg::point_t               res_pt_q;
	logic [nps_pkg::ADDR_BITS-1:0] res_idx_q;
	logic                          res_found_q;
	logic                          res_bad_q;

	nps_pkg::point_t               ring_q [nps_pkg::MAX_POINTS];
	nps_pkg::point_t               ring_in;
	nps_pkg::point_t               head;
	nps_pkg::point_t               in_pt;
	nps_pkg::op_t                  op;
	nps_pkg::cand_t                cand;

	logic                          accept;
	logic                          idx_ok;
	logic                          load_fire;
	logic                          clear_fire;
	logic                          bad_fire;
	logic                          query_fire;
	logic                          rotate;
	logic                          scanning;
	logic                          capturing;
	logic                          finishing;
	logic                          ring_shift;
	logic                          step_last;
	logic                          head_live;
	logic [nps_pkg::CNT_BITS-1:0]  head_idx_full;
	logic [nps_pkg::ADDR_BITS-1:0] head_idx;
	logic                          cand_in_valid;
	logic                          capture_hit;
	logic                          better;

	// ---------------------------------------------------------------- command decode
	assign op         = nps_pkg::op_t'(operation);
	assign accept     = start && !busy;
	assign idx_ok     = {1'b0, query_index} < count_q;
	assign load_fire  = accept && (op == nps_pkg::OP_LOAD)
		&& (count_q < nps_pkg::CNT_BITS'(nps_pkg::MAX_POINTS));
	assign clear_fire = accept && (op == nps_pkg::OP_CLEAR);
	assign bad_fire   = accept && (op == nps_pkg::OP_QUERY_IDX) && !idx_ok;
	assign query_fire = accept && ((op == nps_pkg::OP_QUERY_PT)
		|| ((op == nps_pkg::OP_QUERY_IDX) && idx_ok));

	assign in_pt.x = px;
	assign in_pt.y = py;
	assign in_pt.z = pz;

	// ---------------------------------------------------------------- state machine
	always_comb begin
		state_d = state_q;
		case (state_q)
			nps_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						nps_pkg::OP_QUERY_PT:  state_d = nps_pkg::ST_SCAN;
						nps_pkg::OP_QUERY_IDX: begin
							if (idx_ok) begin
								state_d = nps_pkg::ST_CAPTURE;
							end
						end
						default:               state_d = nps_pkg::ST_IDLE;
					endcase
				end
			end
			nps_pkg::ST_CAPTURE: begin
				if (step_last) begin
					state_d = nps_pkg::ST_SCAN;
				end
			end
			nps_pkg::ST_SCAN: begin
				if (step_last) begin
					state_d = nps_pkg::ST_DRAIN;
				end
			end
			nps_pkg::ST_DRAIN: begin
				if (drain_q == nps_pkg::DRAIN_BITS'(nps_pkg::DRAIN_CYCLES - 1)) begin
					state_d = nps_pkg::ST_FINISH;
				end
			end
			nps_pkg::ST_FINISH: state_d = nps_pkg::ST_IDLE;
			default:            state_d = nps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		capturing = 1'b0;
		scanning  = 1'b0;
		finishing = 1'b0;
		case (state_q)
			nps_pkg::ST_IDLE:    busy      = 1'b0;
			nps_pkg::ST_CAPTURE: capturing = 1'b1;
			nps_pkg::ST_SCAN:    scanning  = 1'b1;
			nps_pkg::ST_FINISH:  finishing = 1'b1;
			default:             busy      = 1'b1;
		endcase
	end

	assign rotate     = capturing || scanning;
	assign ring_shift = rotate || load_fire;
	assign step_last  = step_q == nps_pkg::ADDR_BITS'(nps_pkg::MAX_POINTS - 1);

	// ---------------------------------------------------------------- point ring
	// A load enters at cell 0, so stored index i sits in cell count-1-i. While
	// rotating, the head cell shows the stored points in ascending index order
	// in the last count steps of the turn; a full turn restores the ring.
	assign head    = ring_q[nps_pkg::MAX_POINTS-1];
	assign ring_in = rotate ? head : in_pt;

	for (genvar k = 0; k < nps_pkg::MAX_POINTS; k++) begin : g_ring
		if (k == 0) begin : g_first
			nps_cell u_cell (
				.clk   (clk),
				.shift (ring_shift),
				.d     (ring_in),
				.q     (ring_q[k])
			);
		end else begin : g_rest
			nps_cell u_cell (
				.clk   (clk),
				.shift (ring_shift),
				.d     (ring_q[k-1]),
				.q     (ring_q[k])
			);
		end
	end

	assign head_live     = {1'b0, step_q} >=
		(nps_pkg::CNT_BITS'(nps_pkg::MAX_POINTS) - count_q);
	assign head_idx_full = {1'b0, step_q} + count_q
		- nps_pkg::CNT_BITS'(nps_pkg::MAX_POINTS);
	assign head_idx      = head_idx_full[nps_pkg::ADDR_BITS-1:0];
	assign cand_in_valid = scanning && head_live && !(skip_en_q && (head_idx == skip_q));
	assign capture_hit   = capturing && head_live && (head_idx == skip_q);

	nps_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cand_in_valid),
		.in_idx   (head_idx),
		.in_pt    (head),
		.query    (query_q),
		.cand     (cand)
	);

	// Candidates arrive in ascending index order, so a strict compare keeps the
	// lowest index on a tie.
	assign better = cand.valid && (!have_q || (cand.sq_sum < best_dist_q));

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nps_pkg::ST_IDLE;
			step_q    <= '0;
			count_q   <= '0;
			skip_en_q <= 1'b0;
			drain_q   <= '0;
			have_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= bad_fire || finishing;

			if (load_fire) begin
				count_q <= count_q + nps_pkg::CNT_BITS'(1);
			end else if (clear_fire) begin
				count_q <= '0;
			end

			if (query_fire) begin
				step_q    <= '0;
				skip_en_q <= (op == nps_pkg::OP_QUERY_IDX);
			end else if (rotate) begin
				step_q <= step_last ? '0 : step_q + nps_pkg::ADDR_BITS'(1);
			end

			if (state_q == nps_pkg::ST_DRAIN) begin
				drain_q <= drain_q + nps_pkg::DRAIN_BITS'(1);
			end else begin
				drain_q <= '0;
			end

			if (query_fire) begin
				have_q <= 1'b0;
			end else if (better) begin
				have_q <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		if (query_fire) begin
			query_q <= in_pt;
			skip_q  <= query_index;
		end else if (capture_hit) begin
			query_q <= head;
		end

		if (better) begin
			best_idx_q  <= cand.idx;
			best_pt_q   <= cand.pt;
			best_dist_q <= cand.sq_sum;
		end

		if (bad_fire) begin
			res_pt_q    <= '0;
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
			res_bad_q   <= 1'b1;
		end else if (finishing) begin
			res_pt_q    <= have_q ? best_pt_q : '0;
			res_idx_q   <= have_q ? best_idx_q : '0;
			res_found_q <= have_q;
			res_bad_q   <= 1'b0;
		end
	end

	assign done          = done_q;
	assign nearest_x     = res_pt_q.x;
	assign nearest_y     = res_pt_q.y;
	assign nearest_z     = res_pt_q.z;
	assign nearest_index = res_idx_q;
	assign found         = res_found_q;
	assign bad_index     = res_bad_q;

	// ---------------------------------------------------------------- checks
	`NPS_ASSERT_NOW(a_result_kind, done, !(found && bad_index), "result both found and bad index")
	`NPS_ASSERT_NOW(a_count_range, 1'b1, count_q <= nps_pkg::CNT_BITS'(nps_pkg::MAX_POINTS), "point count beyond capacity")
	`NPS_ASSERT_NEXT(a_query_busy, query_fire, busy && !done, "query taken but block not busy")
	`NPS_ASSERT_NEXT(a_finish_done, finishing, done && !busy, "finished search gave no result")

endmodule

`default_nettype wire

// ----- design/nps_cell.sv -----
// ----------------------------------------------------------------------------
// nps_cell
// One slot of the point ring: holds a point and passes it on when shifted.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_cell (
	input  wire logic           clk,
	input  wire logic           shift,
	input  wire nps_pkg::point_t d,
	output nps_pkg::point_t     q
);

	nps_pkg::point_t pt_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			pt_q <= d;
		end
	end

	assign q = pt_q;

endmodule

`default_nettype wire

// ----- design/nps_dist.sv -----
// ----------------------------------------------------------------------------
// nps_dist
// Three-stage squared-distance pipeline between a candidate and the query.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_dist (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [nps_pkg::ADDR_BITS-1:0] in_idx,
	input  wire nps_pkg::point_t               in_pt,
	input  wire nps_pkg::point_t               query,
	output nps_pkg::cand_t                     cand
);

	logic                          valid_s1, valid_s2, valid_s3;
	logic [nps_pkg::ADDR_BITS-1:0] idx_s1, idx_s2, idx_s3;
	nps_pkg::point_t               pt_s1, pt_s2, pt_s3;
	logic [nps_pkg::COORD_BITS-1:0] dx_s1, dy_s1, dz_s1;
	logic [nps_pkg::SQ_BITS-1:0]    sx_s2, sy_s2, sz_s2;
	logic [nps_pkg::DIST_BITS-1:0]  dist_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= in_idx;
		pt_s1   <= in_pt;
		dx_s1   <= nps_pkg::abs_diff(in_pt.x, query.x);
		dy_s1   <= nps_pkg::abs_diff(in_pt.y, query.y);
		dz_s1   <= nps_pkg::abs_diff(in_pt.z, query.z);

		idx_s2  <= idx_s1;
		pt_s2   <= pt_s1;
		sx_s2   <= nps_pkg::SQ_BITS'(dx_s1) * nps_pkg::SQ_BITS'(dx_s1);
		sy_s2   <= nps_pkg::SQ_BITS'(dy_s1) * nps_pkg::SQ_BITS'(dy_s1);
		sz_s2   <= nps_pkg::SQ_BITS'(dz_s1) * nps_pkg::SQ_BITS'(dz_s1);

		idx_s3  <= idx_s2;
		pt_s3   <= pt_s2;
		dist_s3 <= nps_pkg::DIST_BITS'(sx_s2) + nps_pkg::DIST_BITS'(sy_s2)
			+ nps_pkg::DIST_BITS'(sz_s2);
	end

	assign cand = {valid_s3, idx_s3, pt_s3, dist_s3};

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-point search block. A short table of
// commands covers the empty set, extreme coordinates, ties, bad indexes and
// a clear. Random phases of loads, clears and queries follow, including one
// pass that fills the set past capacity. Start timing is bursty, and every result
// item is checked against its table row or a software brute-force search.
// ---------------------------------------------------------------------------
module tb_top;
	import nps_pkg::*;

	localparam int RANDOM_ITEMS  = 500;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 600;

	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	typedef struct packed {
		point_t               pt;
		logic [ADDR_BITS-1:0] idx;
		logic                 found;
		logic                 bad;
	} nearest_t;

	typedef struct {
		op_t                  op;
		point_t               pt;
		logic [ADDR_BITS-1:0] qi;
		bit                   fixed;
		nearest_t             res;
	} stim_row_t;

	typedef enum int {
		CM_WIDE,
		CM_NARROW,
		CM_EDGE
	} coord_mode_t;

	localparam point_t   P_ZERO  = '{'0, '0, '0};
	localparam point_t   P_MAX   = '{C_MAX, C_MAX, C_MAX};
	localparam point_t   P_MIN   = '{C_MIN, C_MIN, C_MIN};
	localparam nearest_t NO_HIT  = '0;
	localparam nearest_t BAD_IDX = '{P_ZERO, '0, 1'b0, 1'b1};

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [1:0]                   operation;
	logic signed [COORD_BITS-1:0] px;
	logic signed [COORD_BITS-1:0] py;
	logic signed [COORD_BITS-1:0] pz;
	logic [ADDR_BITS-1:0]         query_index;
	logic                         done;
	logic signed [COORD_BITS-1:0] nearest_x;
	logic signed [COORD_BITS-1:0] nearest_y;
	logic signed [COORD_BITS-1:0] nearest_z;
	logic [ADDR_BITS-1:0]         nearest_index;
	logic                         found;
	logic                         bad_index;

	point_t   stored_pts [MAX_POINTS];
	int       stored_count;
	nearest_t pending_nearest [$];
	int       mismatch_count;
	int       burst_left;
	int       sent_items;

	stim_row_t directed_rows [0:24] = '{
		'{OP_QUERY_PT,  P_ZERO, 8'd0,   1'b1, NO_HIT},
		'{OP_QUERY_IDX, P_ZERO, 8'd0,   1'b1, BAD_IDX},
		'{OP_LOAD,      P_MAX,  8'd0,   1'b0, NO_HIT},
		'{OP_QUERY_IDX, P_ZERO, 8'd0,   1'b1, NO_HIT},
		'{OP_QUERY_IDX, P_ZERO, 8'd1,   1'b1, BAD_IDX},
		'{OP_QUERY_PT,  P_MIN,  8'd0,   1'b1, '{P_MAX, 8'd0, 1'b1, 1'b0}},
		'{OP_LOAD,      P_MIN,  8'd0,   1'b0, NO_HIT},
		'{OP_QUERY_PT,  P_MIN,  8'd0,   1'b1, '{P_MIN, 8'd1, 1'b1, 1'b0}},
		'{OP_QUERY_IDX, P_ZERO, 8'd0,   1'b1, '{P_MIN, 8'd1, 1'b1, 1'b0}},
		'{OP_QUERY_IDX, P_ZERO, 8'd1,   1'b1, '{P_MAX, 8'd0, 1'b1, 1'b0}},
		'{OP_LOAD,      P_ZERO, 8'd0,   1'b0, NO_HIT},
		'{OP_LOAD,      P_ZERO, 8'd0,   1'b0, NO_HIT},
		'{OP_QUERY_PT,  P_ZERO, 8'd0,   1'b1, '{P_ZERO, 8'd2, 1'b1, 1'b0}},
		'{OP_QUERY_IDX, P_ZERO, 8'd3,   1'b1, '{P_ZERO, 8'd2, 1'b1, 1'b0}},
		'{OP_QUERY_IDX, P_ZERO, 8'd2,   1'b1, '{P_ZERO, 8'd3, 1'b1, 1'b0}},
		'{OP_LOAD,      '{-24'sd1, 24'sd1, -24'sd256}, 8'd0, 1'b0, NO_HIT},
		'{OP_LOAD,      '{24'sd1, -24'sd1, 24'sd256},  8'd0, 1'b0, NO_HIT},
		'{OP_QUERY_PT,  '{24'sd0, 24'sd0, 24'sd1},     8'd0, 1'b0, NO_HIT},
		'{OP_QUERY_IDX, P_ZERO, 8'd255, 1'b1, BAD_IDX},
		'{OP_QUERY_PT,  '{C_MAX, C_MIN, C_MAX},        8'd0, 1'b0, NO_HIT},
		'{OP_CLEAR,     P_MAX,  8'd255, 1'b0, NO_HIT},
		'{OP_QUERY_PT,  P_ZERO, 8'd0,   1'b1, NO_HIT},
		'{OP_QUERY_IDX, P_ZERO, 8'd0,   1'b1, BAD_IDX},
		'{OP_LOAD,      '{24'sh555555, 24'shAAAAAA, 24'sh0F0F0F}, 8'd0, 1'b0, NO_HIT},
		'{OP_QUERY_PT,  '{24'shAAAAAA, 24'sh555555, 24'shF0F0F0}, 8'd0, 1'b0, NO_HIT}
	};

	nearest_point_search_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.px            (px),
		.py            (py),
		.pz            (pz),
		.query_index   (query_index),
		.done          (done),
		.nearest_x     (nearest_x),
		.nearest_y     (nearest_y),
		.nearest_z     (nearest_z),
		.nearest_index (nearest_index),
		.found         (found),
		.bad_index     (bad_index)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint unsigned squared_gap(point_t a, point_t b);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'($signed(a.x)) - longint'($signed(b.x));
		dy = longint'($signed(a.y)) - longint'($signed(b.y));
		dz = longint'($signed(a.z)) - longint'($signed(b.z));
		return longint'(dx * dx + dy * dy + dz * dz);
	endfunction

	// Applies one command to the local copy of the set and works out the
	// result item that a query returns.
	task automatic nearest_search(input op_t op, input point_t p,
			input logic [ADDR_BITS-1:0] qi, output bit has_result, output nearest_t res);
		point_t          target;
		bit              skip;
		bit              have;
		int              best;
		longint unsigned best_d;
		longint unsigned d;
		res = '0;
		has_result = 1'b0;
		skip = 1'b0;
		have = 1'b0;
		best = 0;
		best_d = 0;
		target = p;
		case (op)
			OP_LOAD: begin
				if (stored_count < MAX_POINTS) begin
					stored_pts[stored_count] = p;
					stored_count++;
				end
			end
			OP_CLEAR: begin
				stored_count = 0;
			end
			default: begin
				has_result = 1'b1;
				if (op == OP_QUERY_IDX) begin
					if (int'(qi) >= stored_count) begin
						res.bad = 1'b1;
					end else begin
						target = stored_pts[qi];
						skip = 1'b1;
					end
				end
				if (!res.bad) begin
					for (int i = 0; i < stored_count; i++) begin
						if (!(skip && i == int'(qi))) begin
							d = squared_gap(stored_pts[i], target);
							if (!have || d < best_d) begin
								have = 1'b1;
								best = i;
								best_d = d;
							end
						end
					end
					if (have) begin
						res.pt = stored_pts[best];
						res.idx = ADDR_BITS'(best);
						res.found = 1'b1;
					end
				end
			end
		endcase
	endtask

	// Drives one item at a falling edge and holds it until it is taken.
	// Items go out in bursts with random gaps between them.
	task automatic issue_command(input op_t op, input point_t p,
			input logic [ADDR_BITS-1:0] qi, input bit use_fixed, input nearest_t fixed_res);
		bit       has_result;
		nearest_t res;
		int       gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 9));
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		start <= 1'b1;
		operation <= op;
		px <= p.x;
		py <= p.y;
		pz <= p.z;
		query_index <= qi;
		@(posedge clk);
		while (busy) @(posedge clk);
		nearest_search(op, p, qi, has_result, res);
		if (has_result)
			pending_nearest = {pending_nearest, (use_fixed ? fixed_res : res)};
		burst_left--;
		sent_items++;
		@(negedge clk);
	endtask

	function automatic logic signed [COORD_BITS-1:0] pick_coord(coord_mode_t mode);
		case (mode)
			CM_WIDE: begin
				return COORD_BITS'($urandom());
			end
			CM_NARROW: begin
				return COORD_BITS'(int'($urandom_range(0, 8)) - 4);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return C_MIN;
					1: return C_MAX;
					2: return '0;
					3: return '1;
					default: return COORD_BITS'(1);
				endcase
			end
		endcase
	endfunction

	function automatic point_t pick_point(coord_mode_t mode);
		point_t p;
		p.x = pick_coord(mode);
		p.y = pick_coord(mode);
		p.z = pick_coord(mode);
		return p;
	endfunction

	// Query points often sit close to a stored point so that the winner is
	// not decided by the extremes alone.
	function automatic point_t pick_query(coord_mode_t mode);
		point_t p;
		if (stored_count > 0 && $urandom_range(0, 1) == 0) begin
			p = stored_pts[$urandom_range(0, stored_count - 1)];
			p.x = p.x + pick_coord(CM_NARROW);
			p.y = p.y + pick_coord(CM_NARROW);
			p.z = p.z + pick_coord(CM_NARROW);
		end else begin
			p = pick_point(mode);
		end
		return p;
	endfunction

	function automatic logic [ADDR_BITS-1:0] pick_index();
		if (stored_count > 0 && $urandom_range(0, 4) != 0)
			return ADDR_BITS'($urandom_range(0, stored_count - 1));
		return ADDR_BITS'($urandom_range(0, MAX_POINTS - 1));
	endfunction

	task automatic random_query(input coord_mode_t mode);
		if ($urandom_range(0, 1) == 0)
			issue_command(OP_QUERY_PT, pick_query(mode), pick_index(), 1'b0, NO_HIT);
		else
			issue_command(OP_QUERY_IDX, pick_point(CM_WIDE), pick_index(), 1'b0, NO_HIT);
	endtask

	task automatic report_field(input string name, input logic [COORD_BITS-1:0] want,
			input logic [COORD_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		nearest_t want;
		if (arst_n && done) begin
			if (pending_nearest.size() == 0) begin
				$display("%0t unexpected result item: expected none actual index %h",
					$time, nearest_index);
				mismatch_count++;
			end else begin
				want = pending_nearest.pop_front();
				report_field("nearest_x", want.pt.x, nearest_x);
				report_field("nearest_y", want.pt.y, nearest_y);
				report_field("nearest_z", want.pt.z, nearest_z);
				report_field("nearest_index", COORD_BITS'(want.idx), COORD_BITS'(nearest_index));
				report_field("found", COORD_BITS'(want.found), COORD_BITS'(found));
				report_field("bad_index", COORD_BITS'(want.bad), COORD_BITS'(bad_index));
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done)
				idle = 0;
			else
				idle++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		bit          filled;
		coord_mode_t mode;
		int          n;
		start = 1'b0;
		operation = OP_LOAD;
		px = '0;
		py = '0;
		pz = '0;
		query_index = '0;
		arst_n = 1'b0;
		stored_count = 0;
		mismatch_count = 0;
		burst_left = 0;
		sent_items = 0;
		filled = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			issue_command(directed_rows[r].op, directed_rows[r].pt, directed_rows[r].qi,
				directed_rows[r].fixed, directed_rows[r].res);

		while (sent_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: mode = CM_WIDE;
				1, 2: mode = CM_EDGE;
				default: mode = CM_NARROW;
			endcase
			if (!filled && sent_items > RANDOM_ITEMS / 3) begin
				// One pass fills the set and keeps loading, so that the
				// surplus items are dropped and index 255 becomes valid.
				filled = 1'b1;
				issue_command(OP_CLEAR, pick_point(CM_WIDE), pick_index(), 1'b0, NO_HIT);
				for (int i = 0; i < MAX_POINTS + 3; i++)
					issue_command(OP_LOAD, pick_point(mode), pick_index(), 1'b0, NO_HIT);
				issue_command(OP_QUERY_IDX, pick_point(CM_WIDE), ADDR_BITS'(MAX_POINTS - 1),
					1'b0, NO_HIT);
				n = $urandom_range(6, 10);
			end else begin
				if ($urandom_range(0, 3) == 0)
					issue_command(OP_CLEAR, pick_point(CM_WIDE), pick_index(), 1'b0, NO_HIT);
				n = $urandom_range(0, 10);
				for (int i = 0; i < n; i++)
					issue_command(OP_LOAD, pick_point(mode), pick_index(), 1'b0, NO_HIT);
				n = $urandom_range(1, 6);
			end
			for (int i = 0; i < n; i++)
				random_query(mode);
			if ($urandom_range(0, 9) == 0)
				issue_command(op_t'($urandom_range(0, 3)), pick_point(CM_WIDE),
					ADDR_BITS'($urandom()), 1'b0, NO_HIT);
		end
		start <= 1'b0;

		while (pending_nearest.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- nearest_point_search_top.f -----
+incdir+design
design/nps_pkg.sv
design/nps_cell.sv
design/nps_dist.sv
design/nearest_point_search_top.sv
tb/tb_top.sv
